// ===== sv/ntc_pkg.sv =====
// Package: thermistor table constants, reciprocals and register indexes for ntc_table_interpolator
`default_nettype none

package ntc_pkg;

	localparam int TABLE_ENTRIES = 12;
	localparam int SEGMENTS      = TABLE_ENTRIES - 1;
	localparam int ADC_W         = 12;
	localparam int TEMP_W        = 16;
	localparam int ERR_W         = 16;
	localparam int SEG_W         = 4;
	localparam int ROW_TEMP_W    = 11;
	localparam int DT_W          = 7;
	localparam int DEN_W         = 9;
	localparam int RECIP_W       = 14;
	localparam int RECIP_SHIFT   = 19;
	localparam int NABS_W        = 19;
	localparam int NUM_W         = 21;
	localparam int Q_W           = 13;
	localparam int T_W           = 15;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [ADC_W-1:0] TEMP_MAX = 12'd2500;

	localparam logic FUNC_STEAM = 1'b1;

	typedef enum logic [1:0] {
		REG_MIN_VALID   = 2'd0,
		REG_MAX_VALID   = 2'd1,
		REG_ERROR_VALUE = 2'd2
	} reg_idx_t;

	localparam logic [ADC_W-1:0] COFFEE_CODES [TABLE_ENTRIES] = '{
		12'd3157, 12'd2844, 12'd2501, 12'd2147, 12'd1939, 12'd1872,
		12'd1806, 12'd1743, 12'd1678, 12'd1616, 12'd1497, 12'd1225
	};

	localparam logic [ADC_W-1:0] STEAM_CODES [TABLE_ENTRIES] = '{
		12'd3167, 12'd2858, 12'd2518, 12'd2165, 12'd1960, 12'd1892,
		12'd1826, 12'd1761, 12'd1698, 12'd1635, 12'd1511, 12'd1227
	};

	localparam logic [ROW_TEMP_W-1:0] ROW_TEMP [TABLE_ENTRIES] = '{
		11'd500, 11'd600, 11'd700, 11'd800, 11'd860, 11'd880,
		11'd900, 11'd920, 11'd940, 11'd960, 11'd1000, 11'd1100
	};

	// floor(2^RECIP_SHIFT / segment ADC span)
	localparam logic [RECIP_W-1:0] COFFEE_RECIP [SEGMENTS] = '{
		14'd1675, 14'd1528, 14'd1481, 14'd2520, 14'd7825, 14'd7943,
		14'd8322, 14'd8065, 14'd8456, 14'd4405, 14'd1927
	};

	localparam logic [RECIP_W-1:0] STEAM_RECIP [SEGMENTS] = '{
		14'd1696, 14'd1542, 14'd1485, 14'd2557, 14'd7710, 14'd7943,
		14'd8065, 14'd8322, 14'd8322, 14'd4228, 14'd1846
	};

	function automatic logic [ADC_W-1:0] adc_code(input logic steam, input logic [SEG_W-1:0] row);
		logic [ADC_W-1:0] code;
		code = steam ? STEAM_CODES[row] : COFFEE_CODES[row];
		return code;
	endfunction

	function automatic logic [RECIP_W-1:0] seg_recip(input logic steam, input logic [SEG_W-1:0] seg);
		logic [RECIP_W-1:0] r;
		r = steam ? STEAM_RECIP[seg] : COFFEE_RECIP[seg];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ntc_table_interpolator.sv =====
// Top level: pipelined thermistor ADC to temperature conversion by table interpolation
// Seven register stages lie between the input transfer and out_valid.
// Throughput: one reading per cycle while out_ready is high; stages hold while the next holds.
// The divide by the segment span is a reciprocal multiply plus one correction step.
// Reset clears every stage valid bit and loads min_valid 0, max_valid 4095, error_value 65535.
`default_nettype none

module ntc_table_interpolator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            func,
	input  wire logic [ntc_pkg::ADC_W-1:0]       adc_sample,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ntc_pkg::TEMP_W-1:0]           temperature,
	output logic                                 sensor_fault,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ntc_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [ntc_pkg::PDATA_W-1:0]     pwdata,
	output logic [ntc_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);

	logic [ntc_pkg::ADC_W-1:0] min_valid_q;
	logic [ntc_pkg::ADC_W-1:0] max_valid_q;
	logic [ntc_pkg::ERR_W-1:0] error_value_q;
	ntc_pkg::reg_idx_t         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = ntc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q   <= '0;
			max_valid_q   <= '1;
			error_value_q <= '1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				ntc_pkg::REG_MIN_VALID:   min_valid_q   <= pwdata[ntc_pkg::ADC_W-1:0];
				ntc_pkg::REG_MAX_VALID:   max_valid_q   <= pwdata[ntc_pkg::ADC_W-1:0];
				ntc_pkg::REG_ERROR_VALUE: error_value_q <= pwdata[ntc_pkg::ERR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ntc_pkg::REG_MIN_VALID:   prdata = ntc_pkg::PDATA_W'(min_valid_q);
			ntc_pkg::REG_MAX_VALID:   prdata = ntc_pkg::PDATA_W'(max_valid_q);
			ntc_pkg::REG_ERROR_VALUE: prdata = ntc_pkg::PDATA_W'(error_value_q);
			default:                  prdata = '0;
		endcase
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	assign rdy_s7 = !v_s7 || out_ready;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: window check and segment select
	logic [ntc_pkg::SEG_W-1:0] seg_c;
	logic                      fault_c;

	always_comb begin
		seg_c = '0;
		for (int i = ntc_pkg::SEGMENTS - 1; i >= 0; i--) begin
			if (adc_sample <= ntc_pkg::adc_code(func, ntc_pkg::SEG_W'(i)) &&
			    adc_sample >= ntc_pkg::adc_code(func, ntc_pkg::SEG_W'(i + 1))) begin
				seg_c = ntc_pkg::SEG_W'(i);
			end
		end
		if (adc_sample <= ntc_pkg::adc_code(func, ntc_pkg::SEG_W'(ntc_pkg::TABLE_ENTRIES - 1)))
			seg_c = ntc_pkg::SEG_W'(ntc_pkg::SEGMENTS - 1);
		if (adc_sample >= ntc_pkg::adc_code(func, '0))
			seg_c = '0;
		fault_c = (adc_sample < min_valid_q) || (adc_sample > max_valid_q);
	end

	logic                      func_s1;
	logic [ntc_pkg::ADC_W-1:0] adc_s1;
	logic [ntc_pkg::SEG_W-1:0] seg_s1;
	logic                      fault_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			func_s1  <= func;
			adc_s1   <= adc_sample;
			seg_s1   <= seg_c;
			fault_s1 <= fault_c;
		end
	end

	// Stage 2: table lookup and offset from segment start
	logic [ntc_pkg::ADC_W-1:0]      a0_c;
	logic [ntc_pkg::ADC_W-1:0]      a1_c;
	logic [ntc_pkg::SEG_W-1:0]      seg_next_c;
	logic [ntc_pkg::ROW_TEMP_W-1:0] t1_c;
	logic [ntc_pkg::ADC_W:0]        diff_c;
	logic [ntc_pkg::ADC_W-1:0]      span_c;
	logic [ntc_pkg::ROW_TEMP_W-1:0] dt_c;

	assign seg_next_c = seg_s1 + 1'b1;
	assign a0_c       = ntc_pkg::adc_code(func_s1, seg_s1);
	assign a1_c       = ntc_pkg::adc_code(func_s1, seg_next_c);
	assign t1_c       = ntc_pkg::ROW_TEMP[seg_next_c];
	assign diff_c     = {1'b0, adc_s1} - {1'b0, a0_c};
	assign span_c     = a0_c - a1_c;
	assign dt_c       = t1_c - ntc_pkg::ROW_TEMP[seg_s1];

	logic signed [ntc_pkg::ADC_W:0]   diff_s2;
	logic [ntc_pkg::DT_W-1:0]         dt_s2;
	logic [ntc_pkg::DEN_W-1:0]        den_s2;
	logic [ntc_pkg::RECIP_W-1:0]      recip_s2;
	logic [ntc_pkg::ROW_TEMP_W-1:0]   t0_s2;
	logic                             fault_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			diff_s2  <= $signed(diff_c);
			dt_s2    <= dt_c[ntc_pkg::DT_W-1:0];
			den_s2   <= span_c[ntc_pkg::DEN_W-1:0];
			recip_s2 <= ntc_pkg::seg_recip(func_s1, seg_s1);
			t0_s2    <= ntc_pkg::ROW_TEMP[seg_s1];
			fault_s2 <= fault_s1;
		end
	end

	// Stage 3: numerator
	logic signed [ntc_pkg::NUM_W-1:0] num_c;

	assign num_c = diff_s2 * $signed({1'b0, dt_s2});

	logic signed [ntc_pkg::NUM_W-1:0] num_s3;
	logic [ntc_pkg::DEN_W-1:0]        den_s3;
	logic [ntc_pkg::RECIP_W-1:0]      recip_s3;
	logic [ntc_pkg::ROW_TEMP_W-1:0]   t0_s3;
	logic                             fault_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			num_s3   <= num_c;
			den_s3   <= den_s2;
			recip_s3 <= recip_s2;
			t0_s3    <= t0_s2;
			fault_s3 <= fault_s2;
		end
	end

	// Stage 4: magnitude times reciprocal gives the quotient estimate
	logic                                         neg_c;
	logic [ntc_pkg::NUM_W-1:0]                    abs_c;
	logic [ntc_pkg::NABS_W-1:0]                   nabs_c;
	logic [ntc_pkg::NABS_W+ntc_pkg::RECIP_W-1:0]  est_c;

	assign neg_c  = num_s3[ntc_pkg::NUM_W-1];
	assign abs_c  = neg_c ? ntc_pkg::NUM_W'(-num_s3) : ntc_pkg::NUM_W'(num_s3);
	assign nabs_c = abs_c[ntc_pkg::NABS_W-1:0];
	assign est_c  = nabs_c * recip_s3;

	logic [ntc_pkg::Q_W-1:0]          qe_s4;
	logic [ntc_pkg::NABS_W-1:0]       nabs_s4;
	logic [ntc_pkg::DEN_W-1:0]        den_s4;
	logic                             sub_s4;
	logic [ntc_pkg::ROW_TEMP_W-1:0]   t0_s4;
	logic                             fault_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			qe_s4    <= est_c[ntc_pkg::RECIP_SHIFT +: ntc_pkg::Q_W];
			nabs_s4  <= nabs_c;
			den_s4   <= den_s3;
			sub_s4   <= !neg_c;
			t0_s4    <= t0_s3;
			fault_s4 <= fault_s3;
		end
	end

	// Stage 5: back-multiply the estimate
	logic [ntc_pkg::Q_W+ntc_pkg::DEN_W-1:0] qd_c;

	assign qd_c = qe_s4 * den_s4;

	logic [ntc_pkg::Q_W-1:0]          qe_s5;
	logic [ntc_pkg::NABS_W-1:0]       qd_s5;
	logic [ntc_pkg::NABS_W-1:0]       nabs_s5;
	logic [ntc_pkg::DEN_W-1:0]        den_s5;
	logic                             sub_s5;
	logic [ntc_pkg::ROW_TEMP_W-1:0]   t0_s5;
	logic                             fault_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			qe_s5    <= qe_s4;
			qd_s5    <= qd_c[ntc_pkg::NABS_W-1:0];
			nabs_s5  <= nabs_s4;
			den_s5   <= den_s4;
			sub_s5   <= sub_s4;
			t0_s5    <= t0_s4;
			fault_s5 <= fault_s4;
		end
	end

	// Stage 6: correct the estimate by one
	logic [ntc_pkg::NABS_W-1:0] rem_c;
	logic [ntc_pkg::Q_W-1:0]    q_c;

	assign rem_c = nabs_s5 - qd_s5;
	assign q_c   = qe_s5 + ntc_pkg::Q_W'(rem_c >= ntc_pkg::NABS_W'(den_s5));

	logic [ntc_pkg::Q_W-1:0]          q_s6;
	logic                             sub_s6;
	logic [ntc_pkg::ROW_TEMP_W-1:0]   t0_s6;
	logic                             fault_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			q_s6     <= q_c;
			sub_s6   <= sub_s5;
			t0_s6    <= t0_s5;
			fault_s6 <= fault_s5;
		end
	end

	// Stage 7: apply sign, clamp, select the error code
	logic signed [ntc_pkg::T_W-1:0] t0_ext_c;
	logic signed [ntc_pkg::T_W-1:0] q_ext_c;
	logic signed [ntc_pkg::T_W-1:0] t_c;
	logic [ntc_pkg::TEMP_W-1:0]     clamp_c;

	assign t0_ext_c = $signed(ntc_pkg::T_W'(t0_s6));
	assign q_ext_c  = $signed(ntc_pkg::T_W'(q_s6));
	assign t_c      = sub_s6 ? (t0_ext_c - q_ext_c) : (t0_ext_c + q_ext_c);

	always_comb begin
		priority if (t_c < 0)
			clamp_c = '0;
		else if (t_c > $signed(ntc_pkg::T_W'(ntc_pkg::TEMP_MAX)))
			clamp_c = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MAX);
		else
			clamp_c = ntc_pkg::TEMP_W'(unsigned'(t_c));
	end

	logic [ntc_pkg::TEMP_W-1:0] temp_s7;
	logic                       fault_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			temp_s7  <= fault_s6 ? error_value_q : clamp_c;
			fault_s7 <= fault_s6;
		end
	end

	assign out_valid    = v_s7;
	assign temperature  = temp_s7;
	assign sensor_fault = fault_s7;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sensor_fault |-> temperature <= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MAX))
		else $error("interpolated temperature above clamp limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> rem_c < {den_s5, 1'b0})
		else $error("reciprocal quotient estimate off by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adc_s1 <= ntc_pkg::adc_code(func_s1, '0) &&
		adc_s1 >= ntc_pkg::adc_code(func_s1, ntc_pkg::SEG_W'(ntc_pkg::TABLE_ENTRIES - 1))
		|-> adc_s1 <= a0_c && adc_s1 >= a1_c)
		else $error("selected segment does not bracket the reading");

endmodule

`default_nettype wire

// ===== dv/ntc_checker.sv =====
// Checker for ntc_table_interpolator: tracks register writes, predicts each reading, compares results
`default_nettype none

module ntc_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic                        func,
	input  wire logic [ntc_pkg::ADC_W-1:0]   adc_sample,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [ntc_pkg::TEMP_W-1:0]  temperature,
	input  wire logic                        sensor_fault,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [ntc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [ntc_pkg::PDATA_W-1:0] pwdata,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ntc_pkg::TEMP_W-1:0] temp;
		logic                       fault;
	} reading_t;

	logic [ntc_pkg::ADC_W-1:0] window_lo;
	logic [ntc_pkg::ADC_W-1:0] window_hi;
	logic [ntc_pkg::ERR_W-1:0] fault_code;
	reading_t                  expected_temps[$];
	reading_t                  head;
	int                        fails;

	function automatic int column_code(input logic steam, input int row);
		return steam ? int'(ntc_pkg::STEAM_CODES[row]) : int'(ntc_pkg::COFFEE_CODES[row]);
	endfunction

	function automatic logic [ntc_pkg::TEMP_W-1:0] segment_temp(input logic steam, input int seg,
			input int adc);
		int a0;
		int a1;
		int t0;
		int t1;
		int den;
		int t;
		a0 = column_code(steam, seg);
		a1 = column_code(steam, seg + 1);
		t0 = int'(ntc_pkg::ROW_TEMP[seg]);
		t1 = int'(ntc_pkg::ROW_TEMP[seg + 1]);
		den = a1 - a0;
		if (den == 0) begin
			t = t0;
		end else begin
			t = t0 + ((adc - a0) * (t1 - t0)) / den;
		end
		if (t < 0) begin
			t = 0;
		end else if (t > int'(ntc_pkg::TEMP_MAX)) begin
			t = int'(ntc_pkg::TEMP_MAX);
		end
		return t[ntc_pkg::TEMP_W-1:0];
	endfunction

	function automatic reading_t predict_reading(input logic steam,
			input logic [ntc_pkg::ADC_W-1:0] code);
		reading_t r;
		int       adc;
		int       seg;
		adc = int'(code);
		if (code < window_lo || code > window_hi) begin
			r.temp  = fault_code;
			r.fault = 1'b1;
			return r;
		end
		if (adc >= column_code(steam, 0)) begin
			seg = 0;
		end else if (adc <= column_code(steam, ntc_pkg::TABLE_ENTRIES - 1)) begin
			seg = ntc_pkg::TABLE_ENTRIES - 2;
		end else begin
			seg = 0;
			for (int i = ntc_pkg::TABLE_ENTRIES - 2; i >= 0; i--) begin
				if (adc <= column_code(steam, i) && adc >= column_code(steam, i + 1)) begin
					seg = i;
				end
			end
		end
		r.temp  = segment_temp(steam, seg, adc);
		r.fault = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_lo  <= '0;
			window_hi  <= '1;
			fault_code <= '1;
			fails = 0;
			expected_temps.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_temps.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, actual temperature %0d fault %0b",
						$time, temperature, sensor_fault);
					fails++;
				end else begin
					head = expected_temps.pop_front();
					if (temperature !== head.temp) begin
						$display("%0t: temperature mismatch, expected %0d, actual %0d",
							$time, head.temp, temperature);
						fails++;
					end
					if (sensor_fault !== head.fault) begin
						$display("%0t: sensor_fault mismatch, expected %0b, actual %0b",
							$time, head.fault, sensor_fault);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_temps.push_back(predict_reading(func, adc_sample));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ntc_pkg::PADDR_W-1:2])
					ntc_pkg::REG_MIN_VALID:   window_lo  <= pwdata[ntc_pkg::ADC_W-1:0];
					ntc_pkg::REG_MAX_VALID:   window_hi  <= pwdata[ntc_pkg::ADC_W-1:0];
					ntc_pkg::REG_ERROR_VALUE: fault_code <= pwdata[ntc_pkg::ERR_W-1:0];
					default: ;
				endcase
			end
			fail_count <= fails;
			pending    <= expected_temps.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench top: stimulus, handshake pacing, register phases and verdict for ntc_table_interpolator
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int SQUEEZE_HOLD = 80;

	localparam logic [ntc_pkg::PADDR_W-1:0] ADDR_MIN_VALID   = {ntc_pkg::REG_MIN_VALID, 2'b00};
	localparam logic [ntc_pkg::PADDR_W-1:0] ADDR_MAX_VALID   = {ntc_pkg::REG_MAX_VALID, 2'b00};
	localparam logic [ntc_pkg::PADDR_W-1:0] ADDR_ERROR_VALUE = {ntc_pkg::REG_ERROR_VALUE, 2'b00};
	localparam logic [ntc_pkg::PADDR_W-1:0] ADDR_UNUSED      = 4'd12;

	localparam logic [ntc_pkg::ADC_W-1:0] EDGE_CODES [12] = '{
		12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd2047,
		12'd3157, 12'd3167, 12'd1225, 12'd1227, 12'd2844, 12'd1939
	};

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        in_valid     = 1'b0;
	logic                        func         = 1'b0;
	logic [ntc_pkg::ADC_W-1:0]   adc_sample   = '0;
	logic                        out_ready    = 1'b0;
	logic                        psel         = 1'b0;
	logic                        penable      = 1'b0;
	logic                        pwrite       = 1'b0;
	logic [ntc_pkg::PADDR_W-1:0] paddr        = '0;
	logic [ntc_pkg::PDATA_W-1:0] pwdata       = '0;
	logic                        in_ready;
	logic                        out_valid;
	logic [ntc_pkg::TEMP_W-1:0]  temperature;
	logic                        sensor_fault;
	logic [ntc_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	int                          fail_count;
	int                          pending;

	logic [ntc_pkg::ADC_W-1:0]   lo_now       = '0;
	logic [ntc_pkg::ADC_W-1:0]   hi_now       = '1;
	int                          burst_left   = 0;
	logic                        squeeze_req  = 1'b0;
	logic                        squeeze_done = 1'b0;
	int                          stall_cycles = 0;

	ntc_table_interpolator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.adc_sample   (adc_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.temperature  (temperature),
		.sensor_fault (sensor_fault),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ntc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.adc_sample   (adc_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.temperature  (temperature),
		.sensor_fault (sensor_fault),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int mode;
		int span;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 40);
			if (squeeze_req && !squeeze_done) begin
				out_ready <= 1'b0;
				repeat (SQUEEZE_HOLD) @(posedge clk);
				squeeze_done <= 1'b1;
			end else begin
				repeat (span) begin
					case (mode)
						0:       out_ready <= 1'b1;
						1:       out_ready <= 1'($urandom_range(0, 1));
						2:       out_ready <= ($urandom_range(0, 3) != 0);
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_reading(input logic steam, input logic [ntc_pkg::ADC_W-1:0] code);
		in_valid   <= 1'b1;
		func       <= steam;
		adc_sample <= code;
		do @(posedge clk); while (!in_ready);
		if (!(squeeze_req && !squeeze_done)) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(0, 30);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ntc_pkg::PADDR_W-1:0] addr,
			input logic [ntc_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [ntc_pkg::ADC_W-1:0] lo,
			input logic [ntc_pkg::ADC_W-1:0] hi, input logic [ntc_pkg::ERR_W-1:0] err);
		logic [ntc_pkg::PDATA_W-1:0] junk;
		junk = $urandom;
		write_reg(ADDR_MIN_VALID, {junk[ntc_pkg::PDATA_W-1:ntc_pkg::ADC_W], lo});
		junk = $urandom;
		write_reg(ADDR_MAX_VALID, {junk[ntc_pkg::PDATA_W-1:ntc_pkg::ADC_W], hi});
		junk = $urandom;
		write_reg(ADDR_ERROR_VALUE, {junk[ntc_pkg::PDATA_W-1:ntc_pkg::ERR_W], err});
		lo_now = lo;
		hi_now = hi;
	endtask

	function automatic logic [ntc_pkg::ADC_W-1:0] pick_code(input logic steam);
		int sel;
		int v;
		int row;
		sel = $urandom_range(0, 99);
		row = $urandom_range(0, ntc_pkg::TABLE_ENTRIES - 1);
		if (sel < 45) begin
			v = $urandom_range(1225, 3167);
		end else if (sel < 70) begin
			v = (steam ? int'(ntc_pkg::STEAM_CODES[row]) : int'(ntc_pkg::COFFEE_CODES[row]))
				+ $urandom_range(0, 4) - 2;
		end else if (sel < 85) begin
			v = $urandom_range(0, 4095);
		end else begin
			v = ($urandom_range(0, 1) ? int'(lo_now) : int'(hi_now)) + $urandom_range(0, 2) - 1;
		end
		if (v < 0) begin
			v = 0;
		end else if (v > 4095) begin
			v = 4095;
		end
		return v[ntc_pkg::ADC_W-1:0];
	endfunction

	task automatic probe_window();
		send_reading(1'($urandom_range(0, 1)), lo_now);
		send_reading(1'($urandom_range(0, 1)), hi_now);
		if (lo_now != '0) begin
			send_reading(1'($urandom_range(0, 1)), lo_now - 1'b1);
		end
		if (hi_now != '1) begin
			send_reading(1'($urandom_range(0, 1)), hi_now + 1'b1);
		end
	endtask

	task automatic run_random(input int count);
		logic steam;
		repeat (count) begin
			steam = 1'($urandom_range(0, 1));
			send_reading(steam, pick_code(steam));
		end
	endtask

	initial begin
		logic [ntc_pkg::ADC_W-1:0] lo;
		logic [ntc_pkg::ADC_W-1:0] hi;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (EDGE_CODES[i]) begin
			send_reading(1'b0, EDGE_CODES[i]);
			send_reading(1'b1, EDGE_CODES[i]);
		end
		settle();

		configure(12'd1500, 12'd2600, 16'hBEEF);
		squeeze_req <= 1'b1;
		probe_window();
		run_random(200);
		settle();

		configure(12'd4095, 12'd0, 16'h0000);
		write_reg(ADDR_UNUSED, $urandom);
		probe_window();
		run_random(50);
		settle();

		configure(12'd0, 12'd0, 16'h0001);
		probe_window();
		run_random(50);
		settle();

		configure(12'd4095, 12'd4095, 16'h8000);
		probe_window();
		run_random(50);
		settle();

		repeat (3) begin
			lo = ntc_pkg::ADC_W'($urandom_range(0, 2000));
			hi = ntc_pkg::ADC_W'($urandom_range(int'(lo), 4095));
			configure(lo, hi, ntc_pkg::ERR_W'($urandom));
			probe_window();
			run_random(80);
			settle();
		end

		configure(12'd0, 12'd4095, 16'hFFFF);
		run_random(150);
		settle();

		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
